>>> design/rad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rad_pkg
// Shared widths, constants, types and helpers for the radix-to-ASCII digit
// converter.
// ----------------------------------------------------------------------------
package rad_pkg;

	// digit store depth and the widths that follow from it
	localparam int MAX_DIGITS = 32;
	localparam int CNT_W      = $clog2(MAX_DIGITS + 1);
	localparam int ADDR_W     = $clog2(MAX_DIGITS);

	// field widths
	localparam int VALUE_W = 32;
	localparam int QUOT_W  = 31;
	localparam int BASE_W  = 6;
	localparam int DIGIT_W = 6;
	localparam int CHAR_W  = 7;
	localparam int WRAP_W  = 8;
	localparam int LEN_W   = $clog2(QUOT_W + 1);
	localparam int LOG_W   = $clog2(BASE_W);

	// character mapping
	localparam logic [CHAR_W-1:0]  ZERO_CHAR     = 7'd48;
	localparam logic [CHAR_W-1:0]  LETTER_OFFSET = 7'd55;
	localparam logic [DIGIT_W-1:0] LAST_DECIMAL  = 6'd9;
	localparam logic [BASE_W-1:0]  MIN_BASE      = 6'd2;

	// request into the shared divider
	typedef struct packed {
		logic              start;
		logic [QUOT_W-1:0] dividend;
		logic [LEN_W-1:0]  len;      // significant dividend bits, 1..31
		logic [BASE_W-1:0] divisor;
	} div_req_t;

	// answer from the shared divider
	typedef struct packed {
		logic               done;
		logic [QUOT_W-1:0]  quotient;
		logic [DIGIT_W-1:0] remainder;
	} div_rsp_t;

	// digit value to ASCII: decimals from '0', the rest from 'A'
	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] ext;
		ext = {{(CHAR_W - DIGIT_W){1'b0}}, d};
		if (d <= LAST_DECIMAL) begin
			return ZERO_CHAR + ext;
		end
		return LETTER_OFFSET + ext;
	endfunction

	// floor(log2) of the base: bits the quotient loses per division at least
	function automatic logic [LOG_W-1:0] base_log2(input logic [BASE_W-1:0] b);
		logic [LOG_W-1:0] r;
		r = '0;
		for (int i = 1; i < BASE_W; i++) begin
			if (b[i]) begin
				r = LOG_W'(i);
			end
		end
		return r;
	endfunction

endpackage

>>> design/rad_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rad_in_if
// Number channel: one signed value and its radix per beat.
// ----------------------------------------------------------------------------
interface rad_in_if;
	logic                               valid;
	logic                               ready;
	logic signed [rad_pkg::VALUE_W-1:0] value;
	logic        [rad_pkg::BASE_W-1:0]  base;

	modport source (output valid, output value, output base, input ready);
	modport sink   (input valid, input value, input base, output ready);
endinterface

>>> design/rad_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rad_out_if
// Digit channel: one ASCII digit per beat, with a flag on the final one.
// ----------------------------------------------------------------------------
interface rad_out_if;
	logic                        valid;
	logic                        ready;
	logic [rad_pkg::CHAR_W-1:0]  digit_char;
	logic                        last;

	modport source (output valid, output digit_char, output last, input ready);
	modport sink   (input valid, input digit_char, input last, output ready);
endinterface

>>> design/rad_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rad_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rad_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/rad_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rad_div
// Bit-serial restoring divider: one quotient bit per cycle, starting at the
// top significant bit of the dividend given by the request length.
// ----------------------------------------------------------------------------
module rad_div (
	input  logic              clk,
	input  logic              arst_n,
	input  rad_pkg::div_req_t req,
	output rad_pkg::div_rsp_t rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic [rad_pkg::QUOT_W-1:0]     dvd_q;
	logic [rad_pkg::BASE_W-1:0]     dsr_q;
	logic [rad_pkg::DIGIT_W-1:0]    rem_q;
	logic [rad_pkg::QUOT_W-1:0]     quo_q;
	logic [rad_pkg::LEN_W-1:0]      idx_q;

	logic [rad_pkg::DIGIT_W:0]      trial;
	logic [rad_pkg::DIGIT_W:0]      diff;
	logic                           fits;

	// trial subtract of the divisor from the partial remainder
	always_comb begin
		trial = {rem_q, dvd_q[idx_q]};
		diff  = trial - {1'b0, dsr_q};
		fits  = trial >= {1'b0, dsr_q};
	end

	// iteration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			dvd_q  <= '0;
			dsr_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			idx_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			dvd_q  <= req.dividend;
			dsr_q  <= req.divisor;
			rem_q  <= '0;
			quo_q  <= '0;
			idx_q  <= req.len - rad_pkg::LEN_W'(1);
		end else if (busy_q) begin
			rem_q        <= fits ? diff[rad_pkg::DIGIT_W-1:0] : trial[rad_pkg::DIGIT_W-1:0];
			quo_q[idx_q] <= fits;
			if (idx_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				idx_q <= idx_q - rad_pkg::LEN_W'(1);
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

>>> design/radix_to_ascii_digits.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_to_ascii_digits
// Converts one integer to ASCII digits in a radix from 2 to 63; above 36 the digits run on past 'Z'.
//
// Usage:
//  - num beats carry a signed value and a base. A negative value is wrapped
//    to its low 8 bits; a base below 2 is taken as 2.
//  - digit beats carry one ASCII character each, most significant first,
//    with last set on the final one. Zero gives a single '0'.
//  - num.ready is high only while the block holds no number.
// Operation:
//  - Each digit costs one pass of the bit-serial divider over len bits,
//    where len starts at 31 and drops by floor(log2 base) per digit.
//  - The digits are then read back from the digit store in reverse order
//    and sent one at a time, each through a read, a wait and a send state.
// Reset clears the sequencer, the digit count and the output valid; the
// digit store keeps no reset. A stalled receiver holds the current digit
// beat steady and the block waits; nothing is lost.
// ----------------------------------------------------------------------------
module radix_to_ascii_digits (
	input  logic       clk,
	input  logic       arst_n,
	rad_in_if.sink     num,
	rad_out_if.source  digit
);

	// sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV  = 3'd1;
	localparam logic [2:0] ST_RD   = 3'd2;
	localparam logic [2:0] ST_WAIT = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	logic [2:0]                     state_q;
	logic [rad_pkg::QUOT_W-1:0]     quo_q;
	logic [rad_pkg::BASE_W-1:0]     base_q;
	logic [rad_pkg::LOG_W-1:0]      k_q;
	logic [rad_pkg::LEN_W-1:0]      len_q;
	logic [rad_pkg::CNT_W-1:0]      cnt_q;
	logic                           start_q;
	logic                           out_valid_q;
	logic [rad_pkg::CHAR_W-1:0]     char_q;
	logic                           last_q;

	logic [rad_pkg::QUOT_W-1:0]     wrapped;
	logic [rad_pkg::BASE_W-1:0]     base_eff;
	logic                           room;
	logic [rad_pkg::LEN_W-1:0]      k_ext;
	logic [rad_pkg::LEN_W-1:0]      len_next;

	rad_pkg::div_req_t              req;
	rad_pkg::div_rsp_t              rsp;

	logic                           ram_we;
	logic [rad_pkg::ADDR_W-1:0]     ram_waddr;
	logic [rad_pkg::ADDR_W-1:0]     ram_raddr;
	logic [rad_pkg::DIGIT_W-1:0]    ram_rdata;

	// input conditioning: 8-bit wrap of negatives, base floor of 2
	always_comb begin
		if (num.value[rad_pkg::VALUE_W-1]) begin
			wrapped = {{(rad_pkg::QUOT_W - rad_pkg::WRAP_W){1'b0}},
			           num.value[rad_pkg::WRAP_W-1:0]};
		end else begin
			wrapped = num.value[rad_pkg::QUOT_W-1:0];
		end
		base_eff = (num.base < rad_pkg::MIN_BASE) ? rad_pkg::MIN_BASE : num.base;
	end

	// shrinking bound on quotient length, never below one bit
	always_comb begin
		k_ext    = rad_pkg::LEN_W'(k_q);
		len_next = (len_q > k_ext) ? (len_q - k_ext) : rad_pkg::LEN_W'(1);
		room     = cnt_q < rad_pkg::CNT_W'(rad_pkg::MAX_DIGITS);
	end

	// divider request
	assign req.start    = start_q;
	assign req.dividend = quo_q;
	assign req.len      = len_q;
	assign req.divisor  = base_q;

	rad_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// digit store: push remainders, pop in reverse
	assign ram_we    = (state_q == ST_DIV) && rsp.done && room;
	assign ram_waddr = cnt_q[rad_pkg::ADDR_W-1:0];
	assign ram_raddr = rad_pkg::ADDR_W'(cnt_q - rad_pkg::CNT_W'(1));

	rad_ram #(
		.WIDTH (rad_pkg::DIGIT_W),
		.DEPTH (rad_pkg::MAX_DIGITS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (rsp.remainder),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			quo_q       <= '0;
			base_q      <= '0;
			k_q         <= '0;
			len_q       <= '0;
			cnt_q       <= '0;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			char_q      <= '0;
			last_q      <= 1'b0;
		end else begin
			start_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (num.valid) begin
						quo_q   <= wrapped;
						base_q  <= base_eff;
						k_q     <= rad_pkg::base_log2(base_eff);
						len_q   <= rad_pkg::LEN_W'(rad_pkg::QUOT_W);
						cnt_q   <= '0;
						start_q <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (rsp.done) begin
						if (room) begin
							cnt_q <= cnt_q + rad_pkg::CNT_W'(1);
						end
						if (rsp.quotient == '0) begin
							state_q <= ST_RD;
						end else begin
							quo_q   <= rsp.quotient;
							len_q   <= len_next;
							start_q <= 1'b1;
						end
					end
				end
				ST_RD: begin
					cnt_q   <= cnt_q - rad_pkg::CNT_W'(1);
					state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					char_q      <= rad_pkg::digit_to_ascii(ram_rdata);
					last_q      <= (cnt_q == '0);
					out_valid_q <= 1'b1;
					state_q     <= ST_OUT;
				end
				ST_OUT: begin
					if (digit.ready) begin
						out_valid_q <= 1'b0;
						state_q     <= (cnt_q == '0) ? ST_IDLE : ST_RD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign num.ready        = (state_q == ST_IDLE);
	assign digit.valid      = out_valid_q;
	assign digit.digit_char = char_q;
	assign digit.last       = last_q;

	// checks
	a_valid_in_out: assert property (@(posedge clk) disable iff (!arst_n)
		digit.valid |-> state_q == ST_OUT)
		else $error("digit beat offered outside the send state");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= rad_pkg::CNT_W'(rad_pkg::MAX_DIGITS))
		else $error("digit count beyond store depth");

	a_last_empty: assert property (@(posedge clk) disable iff (!arst_n)
		digit.valid && digit.last |-> cnt_q == '0)
		else $error("last flag with digits still stored");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start_q |-> $past(state_q) == ST_IDLE || $past(rsp.done))
		else $error("divider started without a finished step");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the radix-to-ASCII digit converter. A short table
// of hand-picked numbers (zero, wrapped negatives, the 31-bit extreme, bases
// out of range) is followed by a couple of hundred random numbers. Each
// accepted number is expanded into its expected digit beats by a local
// predictor, or taken from the table where the answer is obvious. Every digit
// beat is compared with the oldest expected one. Both channels idle in random
// bursts except over the closing stretch.
// ----------------------------------------------------------------------------
module tb;

	localparam int RANDOM_ITEMS = 226;
	localparam int CALM_ITEMS   = 40;      // closing stretch with no idling
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 1500000;
	localparam int SHOW_LIMIT   = 10;

	typedef struct packed {
		logic [rad_pkg::CHAR_W-1:0] ch;
		logic                       last;
	} digit_beat_t;

	typedef struct {
		logic [rad_pkg::VALUE_W-1:0] value;
		logic [rad_pkg::BASE_W-1:0]  base;
		string                       want;      // empty: ask the predictor
	} probe_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        quiet = 1'b0;
	int unsigned cycles = 0;
	int unsigned mismatches = 0;

	digit_beat_t digits_due[$];
	digit_beat_t head;
	probe_t      probes[$];

	rad_in_if  num_ch ();
	rad_out_if digit_ch ();

	radix_to_ascii_digits u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_ch),
		.digit  (digit_ch)
	);

	always #6 clk = ~clk;

	// run guard
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** radix_to_ascii_digits: FAILED **");
			$finish;
		end
	end

	task automatic flag_mismatch(input string what, input digit_beat_t want,
			input digit_beat_t got);
		mismatches++;
		if (mismatches <= SHOW_LIMIT) begin
			$display("mismatch @%0t: %s exp char=%0d last=%0b got char=%0d last=%0b",
				$realtime, what, want.ch, want.last, got.ch, got.last);
		end
	endtask

	// expected digits of one number, most significant first
	function automatic void expand_number(input logic [rad_pkg::VALUE_W-1:0] raw,
			input logic [rad_pkg::BASE_W-1:0] b);
		logic [rad_pkg::VALUE_W-1:0] word;
		logic [rad_pkg::QUOT_W-1:0]  quot;
		logic [rad_pkg::BASE_W-1:0]  radix;
		logic [rad_pkg::DIGIT_W-1:0] held[$];
		logic [rad_pkg::DIGIT_W-1:0] d;
		digit_beat_t                 beat;
		word = raw;
		// negatives keep only their low byte
		if (word[rad_pkg::VALUE_W-1]) begin
			word = {{(rad_pkg::VALUE_W - rad_pkg::WRAP_W){1'b0}},
				word[rad_pkg::WRAP_W-1:0]};
		end
		radix = (b < rad_pkg::MIN_BASE) ? rad_pkg::MIN_BASE : b;
		quot  = word[rad_pkg::QUOT_W-1:0];
		do begin
			if (held.size() < rad_pkg::MAX_DIGITS) begin
				held.push_back(rad_pkg::DIGIT_W'(quot % radix));
			end
			quot = quot / radix;
		end while (quot != 0);
		while (held.size() != 0) begin
			d = held.pop_back();
			beat.ch = (d <= rad_pkg::LAST_DECIMAL)
				? rad_pkg::ZERO_CHAR + rad_pkg::CHAR_W'(d)
				: rad_pkg::LETTER_OFFSET + rad_pkg::CHAR_W'(d);
			beat.last = (held.size() == 0);
			digits_due.push_back(beat);
		end
	endfunction

	// typed-in answer: one beat per character, last on the final one
	function automatic void expand_text(input string want);
		digit_beat_t beat;
		logic [7:0]  c;
		for (int i = 0; i < want.len(); i++) begin
			c = want[i];
			beat.ch = c[rad_pkg::CHAR_W-1:0];
			beat.last = (i == want.len() - 1);
			digits_due.push_back(beat);
		end
	endfunction

	function automatic void add_probe(input logic [rad_pkg::VALUE_W-1:0] v,
			input logic [rad_pkg::BASE_W-1:0] b, input string want);
		probe_t p;
		p.value = v;
		p.base  = b;
		p.want  = want;
		probes.push_back(p);
	endfunction

	// one number beat; valid stays up for the caller to lower or reuse, unless a random gap lowers it
	task automatic send_number(input logic [rad_pkg::VALUE_W-1:0] v,
			input logic [rad_pkg::BASE_W-1:0] b, input string want);
		num_ch.valid <= 1'b1;
		num_ch.value <= v;
		num_ch.base  <= b;
		do @(posedge clk); while (!num_ch.ready);
		if (want == "") begin
			expand_number(v, b);
		end else begin
			expand_text(want);
		end
		// random gap on the number side
		if (!quiet && $urandom_range(0, 2) == 0) begin
			num_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	// number side
	initial begin
		logic [rad_pkg::VALUE_W-1:0] v;
		logic [rad_pkg::BASE_W-1:0]  b;
		num_ch.valid = 1'b0;
		num_ch.value = '0;
		num_ch.base  = '0;
		arst_n = 1'b0;

		add_probe(32'd0,          6'd10, "0");
		add_probe(32'hFFFF_FFFF,  6'd16, "FF");
		add_probe(32'hFFFF_FF80,  6'd10, "128");
		add_probe(32'hFFFF_FF7F,  6'd10, "127");       // below -128: low byte only
		add_probe(32'h8000_0000,  6'd10, "0");
		add_probe(32'hAAAA_AAAA,  6'd16, "AA");
		add_probe(32'h7FFF_FFFF,  6'd16, "7FFFFFFF");
		add_probe(32'h7FFF_FFFF,  6'd10, "2147483647");
		add_probe(32'h7FFF_FFFF,  6'd2,  "");          // longest number, 31 digits
		add_probe(32'h7FFF_FFFF,  6'd36, "");
		add_probe(32'd35,         6'd36, "Z");
		add_probe(32'd36,         6'd36, "10");
		add_probe(32'd9,          6'd10, "9");
		add_probe(32'd10,         6'd11, "A");
		add_probe(32'd5,          6'd0,  "101");       // base 0 runs as base 2
		add_probe(32'd3,          6'd1,  "11");        // base 1 likewise
		add_probe(32'd62,         6'd63, "u");         // base above 36
		add_probe(32'hFFFF_FFFF,  6'd63, "43");
		add_probe(32'd1,          6'd2,  "1");
		add_probe(32'd255,        6'd2,  "11111111");
		add_probe(32'd123456789,  6'd10, "123456789");
		add_probe(32'hFFFF_FFFE,  6'd3,  "");
		add_probe(32'h5555_5555,  6'd4,  "");
		add_probe(32'h4000_0000,  6'd37, "");

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i]) begin
			send_number(probes[i].value, probes[i].base, probes[i].want);
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n >= RANDOM_ITEMS - CALM_ITEMS) begin
				quiet = 1'b1;
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					v = ($urandom & 32'h7FFF_FFFF) >> $urandom_range(0, 30);
				end
				4, 5: begin
					v = $urandom;
				end
				6: begin
					v = 32'hFFFF_FF80 | $urandom_range(0, 127);
				end
				7: begin
					v = $urandom_range(0, 40);
				end
				default: begin
					v = $urandom & 32'h7FFF_FFFF;
				end
			endcase
			b = ($urandom_range(0, 7) == 0) ? rad_pkg::BASE_W'($urandom_range(0, 63))
				: rad_pkg::BASE_W'($urandom_range(2, 36));
			send_number(v, b, "");
		end
		num_ch.valid <= 1'b0;

		while (digits_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("** radix_to_ascii_digits: PASSED **");
		end else begin
			$display("** radix_to_ascii_digits: FAILED **");
		end
		$finish;
	end

	// digit side back-pressure
	initial begin
		digit_ch.ready = 1'b0;
		wait (arst_n);
		forever begin
			if (!quiet && $urandom_range(0, 2) == 0) begin
				digit_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(posedge clk);
			end
			digit_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 20)) @(posedge clk);
		end
	end

	// compare each digit beat with the oldest one due
	always @(posedge clk) begin
		if (arst_n && digit_ch.valid && digit_ch.ready) begin
			if (digits_due.size() == 0) begin
				flag_mismatch("digit beat with none due", '0,
					{digit_ch.digit_char, digit_ch.last});
			end else begin
				head = digits_due.pop_front();
				if (head.ch !== digit_ch.digit_char || head.last !== digit_ch.last) begin
					flag_mismatch("digit beat", head, {digit_ch.digit_char, digit_ch.last});
				end
			end
		end
	end

endmodule
